@@ sv/acn_pkg.sv @@
package acn_pkg;

  localparam int FRACTION_BITS = 15;
  localparam int VAL_W         = FRACTION_BITS + 2;
  localparam int MAG_W         = VAL_W;
  localparam int SQ_W          = 2 * MAG_W;
  localparam int STICK_W       = 16;
  localparam int TILT_W        = 17;
  localparam int DZ_W          = 16;
  localparam int INV_W         = 2;
  localparam int SRC_W         = 5;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int QUOT_W        = FRACTION_BITS + 1;
  localparam int CNT_W         = $clog2(FRACTION_BITS + 1);
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_MASK   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_ENABLE = 2'd2;

  localparam logic [SRC_W-1:0] SOURCE_ENABLE_RST = 5'd31;

  localparam int SRC_KEY      = 0;
  localparam int SRC_KEY_AXES = 1;
  localparam int SRC_TILT     = 2;
  localparam int SRC_BUTTON   = 3;
  localparam int SRC_STICK    = 4;

  localparam int INV_X = 0;
  localparam int INV_Y = 1;

  // stick axis treatment decided at the front
  localparam logic [1:0] SM_ZERO = 2'd0;
  localparam logic [1:0] SM_RAW  = 2'd1;
  localparam logic [1:0] SM_DIV  = 2'd2;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [MAG_W-1:0]        mag_t;

  localparam val_t ONE_V     = val_t'(1) <<< FRACTION_BITS;
  localparam val_t NEG_ONE_V = -ONE_V;
  localparam val_t ZERO_V    = '0;
  localparam mag_t ONE_M     = mag_t'(1) << FRACTION_BITS;
  localparam logic [SQ_W:0] HALF_SQ = (SQ_W + 1)'(1) << (2 * FRACTION_BITS - 2);

  typedef struct packed {
    logic [1:0]                mode;
    logic                      neg;
    logic signed [STICK_W-1:0] raw;
    logic [STICK_W-1:0]        num;
    logic [STICK_W-1:0]        den;
  } stick_axis_t;

  typedef struct packed {
    val_t              x_pre;
    val_t              y_pre;
    logic              stick_en;
    logic [INV_W-1:0]  inv;
    stick_axis_t       ax;
    stick_axis_t       ay;
  } work_t;

  function automatic mag_t mag_of(val_t v);
    return v[VAL_W-1] ? mag_t'(-v) : mag_t'(v);
  endfunction

  // later source wins on a tie
  function automatic val_t pick(val_t cur, val_t cand);
    return (mag_of(cand) >= mag_of(cur)) ? cand : cur;
  endfunction

endpackage

@@ sv/input_action_conditioner_core.sv @@
// Input action conditioner: turns one frame of raw control inputs into the
// combined action vector and its press/release edges.
// Input channel: in_valid/in_stall with one port per field; an item is a
//   transfer at a clock edge with in_valid high and in_stall low.
// Result channel: out_valid/out_stall, one result per input item, in order.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 deadzone,
//   1 invert mask, 2 source enable); write only while the block is idle.
// Back end: it loads an item from the queue, runs the shared-step restoring
//   divider for the stick rescale, then picks, squares and compares; it
//   takes the next item from the queue only once it has written the result.
// The front end classifies an item in its transfer cycle and writes it into a
//   small queue, so inputs are taken while the back end is busy or a result
//   is held; in_stall rises only when that queue is full.
// Reset (rst_n low at a clock edge) empties the queue, drops any item at work,
//   clears the output and the previous-frame down flag, and loads the
//   register defaults: no deadzone, no inversion, all sources enabled.
// When the receiver stalls, the result holds on the ports unchanged; the back
//   end keeps working on the next item and waits only to write its result.
module input_action_conditioner_core #(
  parameter int QUEUE_DEPTH = acn_pkg::QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [acn_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [acn_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_key_held,
  input  logic                                in_neg_x_held,
  input  logic                                in_pos_x_held,
  input  logic                                in_neg_y_held,
  input  logic                                in_pos_y_held,
  input  logic signed [acn_pkg::TILT_W-1:0]   in_tilt_x,
  input  logic signed [acn_pkg::TILT_W-1:0]   in_tilt_y,
  input  logic                                in_button_held,
  input  logic signed [acn_pkg::STICK_W-1:0]  in_stick_x,
  input  logic signed [acn_pkg::STICK_W-1:0]  in_stick_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [acn_pkg::VAL_W-1:0]    out_value_x,
  output logic signed [acn_pkg::VAL_W-1:0]    out_value_y,
  output logic                                out_is_down,
  output logic                                out_went_down,
  output logic                                out_went_up
);

  // configuration registers
  logic [acn_pkg::DZ_W-1:0]  dead_zone_r;
  logic [acn_pkg::INV_W-1:0] invert_mask_r;
  logic [acn_pkg::SRC_W-1:0] source_enable_r;

  // front to queue to back
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;
  acn_pkg::work_t wr_data;
  acn_pkg::work_t rd_data;

  // take a write on any edge with cfg_we; an unknown index is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_zone_r     <= '0;
      invert_mask_r   <= '0;
      source_enable_r <= acn_pkg::SOURCE_ENABLE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        acn_pkg::CFG_DEAD_ZONE:     dead_zone_r     <= cfg_data[acn_pkg::DZ_W-1:0];
        acn_pkg::CFG_INVERT_MASK:   invert_mask_r   <= cfg_data[acn_pkg::INV_W-1:0];
        acn_pkg::CFG_SOURCE_ENABLE: source_enable_r <= cfg_data[acn_pkg::SRC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // classify the item and combine the non-stick sources
  acn_front u_front (
    .in_valid      (in_valid),
    .q_full        (q_full),
    .in_stall      (in_stall),
    .push          (push),
    .dead_zone     (dead_zone_r),
    .invert_mask   (invert_mask_r),
    .source_enable (source_enable_r),
    .key_held      (in_key_held),
    .neg_x_held    (in_neg_x_held),
    .pos_x_held    (in_pos_x_held),
    .neg_y_held    (in_neg_y_held),
    .pos_y_held    (in_pos_y_held),
    .tilt_x        (in_tilt_x),
    .tilt_y        (in_tilt_y),
    .button_held   (in_button_held),
    .stick_x       (in_stick_x),
    .stick_y       (in_stick_y),
    .wr_data       (wr_data)
  );

  // decouple the front from the slow back end
  acn_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (wr_data),
    .pop     (pop),
    .rd_data (rd_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  // rescale the stick, finish the pick, square, compare and drive the result
  acn_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .rd_data       (rd_data),
    .empty         (q_empty),
    .pop           (pop),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_value_x   (out_value_x),
    .out_value_y   (out_value_y),
    .out_is_down   (out_is_down),
    .out_went_down (out_went_down),
    .out_went_up   (out_went_up)
  );

endmodule

@@ sv/acn_front.sv @@
module acn_front (
  input  logic                              in_valid,
  input  logic                              q_full,
  output logic                              in_stall,
  output logic                              push,
  input  logic [acn_pkg::DZ_W-1:0]          dead_zone,
  input  logic [acn_pkg::INV_W-1:0]         invert_mask,
  input  logic [acn_pkg::SRC_W-1:0]         source_enable,
  input  logic                              key_held,
  input  logic                              neg_x_held,
  input  logic                              pos_x_held,
  input  logic                              neg_y_held,
  input  logic                              pos_y_held,
  input  logic signed [acn_pkg::TILT_W-1:0] tilt_x,
  input  logic signed [acn_pkg::TILT_W-1:0] tilt_y,
  input  logic                              button_held,
  input  logic signed [acn_pkg::STICK_W-1:0] stick_x,
  input  logic signed [acn_pkg::STICK_W-1:0] stick_y,
  output acn_pkg::work_t                    wr_data
);

  function automatic acn_pkg::val_t sat_one(logic signed [acn_pkg::TILT_W-1:0] v);
    acn_pkg::val_t r;
    r = acn_pkg::val_t'(v);
    if (v > acn_pkg::TILT_W'(acn_pkg::ONE_V)) begin
      r = acn_pkg::ONE_V;
    end else if (v < acn_pkg::TILT_W'(acn_pkg::NEG_ONE_V)) begin
      r = acn_pkg::NEG_ONE_V;
    end
    return r;
  endfunction

  function automatic acn_pkg::stick_axis_t classify(
    logic signed [acn_pkg::STICK_W-1:0] raw,
    logic [acn_pkg::DZ_W-1:0]           dz
  );
    acn_pkg::stick_axis_t a;
    acn_pkg::mag_t        m;
    acn_pkg::mag_t        dzm;
    m     = acn_pkg::mag_of(acn_pkg::val_t'(raw));
    dzm   = acn_pkg::mag_t'(dz);
    a.raw = raw;
    a.neg = raw[acn_pkg::STICK_W-1];
    a.num = acn_pkg::STICK_W'(m - dzm);
    a.den = acn_pkg::STICK_W'(acn_pkg::ONE_M - dzm);
    if (dz == '0) begin
      a.mode = acn_pkg::SM_RAW;
    end else if (dzm >= acn_pkg::ONE_M || m <= dzm) begin
      a.mode = acn_pkg::SM_ZERO;
    end else begin
      a.mode = acn_pkg::SM_DIV;
    end
    return a;
  endfunction

  acn_pkg::val_t x_c;
  acn_pkg::val_t y_c;
  acn_pkg::val_t kx_c;
  acn_pkg::val_t ky_c;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // combine every source except the stick in the fixed order
  always_comb begin
    x_c  = acn_pkg::ZERO_V;
    y_c  = acn_pkg::ZERO_V;
    kx_c = (pos_x_held ? acn_pkg::ONE_V : acn_pkg::ZERO_V)
         - (neg_x_held ? acn_pkg::ONE_V : acn_pkg::ZERO_V);
    ky_c = (pos_y_held ? acn_pkg::ONE_V : acn_pkg::ZERO_V)
         - (neg_y_held ? acn_pkg::ONE_V : acn_pkg::ZERO_V);
    if (source_enable[acn_pkg::SRC_KEY]) begin
      x_c = acn_pkg::pick(x_c, key_held ? acn_pkg::ONE_V : acn_pkg::ZERO_V);
    end
    if (source_enable[acn_pkg::SRC_BUTTON]) begin
      x_c = acn_pkg::pick(x_c, button_held ? acn_pkg::ONE_V : acn_pkg::ZERO_V);
    end
    if (source_enable[acn_pkg::SRC_KEY_AXES]) begin
      x_c = acn_pkg::pick(x_c, kx_c);
      y_c = acn_pkg::pick(y_c, ky_c);
    end
    if (source_enable[acn_pkg::SRC_TILT]) begin
      x_c = acn_pkg::pick(x_c, sat_one(tilt_x));
      y_c = acn_pkg::pick(y_c, sat_one(tilt_y));
    end
  end

  always_comb begin
    wr_data.x_pre    = x_c;
    wr_data.y_pre    = y_c;
    wr_data.stick_en = source_enable[acn_pkg::SRC_STICK];
    wr_data.inv      = invert_mask;
    wr_data.ax       = classify(stick_x, dead_zone);
    wr_data.ay       = classify(stick_y, dead_zone);
  end

endmodule

@@ sv/acn_queue.sv @@
module acn_queue #(
  parameter int DEPTH = acn_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  acn_pkg::work_t wr_data,
  input  logic           pop,
  output acn_pkg::work_t rd_data,
  output logic           full,
  output logic           empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  acn_pkg::work_t  entry_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r;
  logic [PW-1:0]   rd_ptr_nxt;
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   count_nxt;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign rd_data = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ sv/acn_back.sv @@
module acn_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  acn_pkg::work_t         rd_data,
  input  logic                   empty,
  output logic                   pop,
  input  logic                   out_stall,
  output logic                   out_valid,
  output logic signed [acn_pkg::VAL_W-1:0] out_value_x,
  output logic signed [acn_pkg::VAL_W-1:0] out_value_y,
  output logic                   out_is_down,
  output logic                   out_went_down,
  output logic                   out_went_up
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_PICK = 3'd2;
  localparam logic [2:0] ST_SQ   = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  localparam int SW = acn_pkg::STICK_W;
  localparam int QW = acn_pkg::QUOT_W;
  localparam logic [acn_pkg::CNT_W-1:0] LAST_STEP = acn_pkg::CNT_W'(acn_pkg::FRACTION_BITS - 1);

  function automatic acn_pkg::val_t stick_val(acn_pkg::stick_axis_t a, logic [QW-1:0] q,
                                              logic inv);
    acn_pkg::val_t v;
    case (a.mode)
      acn_pkg::SM_RAW: v = acn_pkg::val_t'(a.raw);
      acn_pkg::SM_DIV: v = a.neg ? -acn_pkg::val_t'(q) : acn_pkg::val_t'(q);
      default:         v = acn_pkg::ZERO_V;
    endcase
    return inv ? -v : v;
  endfunction

  logic [2:0]                  state_r,  state_nxt;
  logic [acn_pkg::CNT_W-1:0]   cnt_r,    cnt_nxt;
  acn_pkg::work_t              work_r,   work_nxt;
  logic [SW-1:0]               rx_r,     rx_nxt;
  logic [SW-1:0]               ry_r,     ry_nxt;
  logic [QW-1:0]               qx_r,     qx_nxt;
  logic [QW-1:0]               qy_r,     qy_nxt;
  acn_pkg::val_t               x_r,      x_nxt;
  acn_pkg::val_t               y_r,      y_nxt;
  logic [acn_pkg::SQ_W-1:0]    sqx_r,    sqx_nxt;
  logic [acn_pkg::SQ_W-1:0]    sqy_r,    sqy_nxt;
  logic                        vld_r,    vld_nxt;
  acn_pkg::val_t               ox_r,     ox_nxt;
  acn_pkg::val_t               oy_r,     oy_nxt;
  logic                        down_r,   down_nxt;
  logic                        wd_r,     wd_nxt;
  logic                        wu_r,     wu_nxt;
  logic                        was_r,    was_nxt;

  logic [SW:0]                 rx2_c;
  logic [SW:0]                 ry2_c;
  logic [acn_pkg::SQ_W:0]      sum_c;
  logic                        now_c;
  acn_pkg::mag_t               mx_c;
  acn_pkg::mag_t               my_c;

  assign pop           = (state_r == ST_IDLE) && !empty;
  assign out_valid     = vld_r;
  assign out_value_x   = ox_r;
  assign out_value_y   = oy_r;
  assign out_is_down   = down_r;
  assign out_went_down = wd_r;
  assign out_went_up   = wu_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    work_nxt  = work_r;
    rx_nxt    = rx_r;
    ry_nxt    = ry_r;
    qx_nxt    = qx_r;
    qy_nxt    = qy_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    sqx_nxt   = sqx_r;
    sqy_nxt   = sqy_r;
    vld_nxt   = vld_r && out_stall;
    ox_nxt    = ox_r;
    oy_nxt    = oy_r;
    down_nxt  = down_r;
    wd_nxt    = wd_r;
    wu_nxt    = wu_r;
    was_nxt   = was_r;
    rx2_c     = {rx_r, 1'b0};
    ry2_c     = {ry_r, 1'b0};
    mx_c      = acn_pkg::mag_of(x_r);
    my_c      = acn_pkg::mag_of(y_r);
    sum_c     = {1'b0, sqx_r} + {1'b0, sqy_r};
    now_c     = sum_c > acn_pkg::HALF_SQ;

    case (state_r)
      ST_IDLE: begin
        if (!empty) begin
          work_nxt = rd_data;
          cnt_nxt  = '0;
          // integer bit of the quotient is set when num is at least den (in divide mode, only when they are equal)
          if (rd_data.ax.num >= rd_data.ax.den) begin
            rx_nxt = rd_data.ax.num - rd_data.ax.den;
            qx_nxt = QW'(1);
          end else begin
            rx_nxt = rd_data.ax.num;
            qx_nxt = '0;
          end
          if (rd_data.ay.num >= rd_data.ay.den) begin
            ry_nxt = rd_data.ay.num - rd_data.ay.den;
            qy_nxt = QW'(1);
          end else begin
            ry_nxt = rd_data.ay.num;
            qy_nxt = '0;
          end
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // one restoring step per axis
        if (rx2_c >= {1'b0, work_r.ax.den}) begin
          rx_nxt = SW'(rx2_c - {1'b0, work_r.ax.den});
          qx_nxt = {qx_r[QW-2:0], 1'b1};
        end else begin
          rx_nxt = rx2_c[SW-1:0];
          qx_nxt = {qx_r[QW-2:0], 1'b0};
        end
        if (ry2_c >= {1'b0, work_r.ay.den}) begin
          ry_nxt = SW'(ry2_c - {1'b0, work_r.ay.den});
          qy_nxt = {qy_r[QW-2:0], 1'b1};
        end else begin
          ry_nxt = ry2_c[SW-1:0];
          qy_nxt = {qy_r[QW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + acn_pkg::CNT_W'(1);
        if (cnt_r == LAST_STEP) begin
          state_nxt = ST_PICK;
        end
      end
      ST_PICK: begin
        x_nxt = work_r.x_pre;
        y_nxt = work_r.y_pre;
        if (work_r.stick_en) begin
          x_nxt = acn_pkg::pick(work_r.x_pre,
                    stick_val(work_r.ax, qx_r, work_r.inv[acn_pkg::INV_X]));
          y_nxt = acn_pkg::pick(work_r.y_pre,
                    stick_val(work_r.ay, qy_r, work_r.inv[acn_pkg::INV_Y]));
        end
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        sqx_nxt   = mx_c * mx_c;
        sqy_nxt   = my_c * my_c;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!vld_r || !out_stall) begin
          vld_nxt   = 1'b1;
          ox_nxt    = x_r;
          oy_nxt    = y_r;
          down_nxt  = now_c;
          wd_nxt    = now_c && !was_r;
          wu_nxt    = !now_c && was_r;
          was_nxt   = now_c;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      vld_r   <= 1'b0;
      was_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      vld_r   <= vld_nxt;
      was_r   <= was_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    rx_r   <= rx_nxt;
    ry_r   <= ry_nxt;
    qx_r   <= qx_nxt;
    qy_r   <= qy_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    sqx_r  <= sqx_nxt;
    sqy_r  <= sqy_nxt;
    ox_r   <= ox_nxt;
    oy_r   <= oy_nxt;
    down_r <= down_nxt;
    wd_r   <= wd_nxt;
    wu_r   <= wu_nxt;
  end

endmodule

@@ sv/acn_checker.sv @@
module acn_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic signed [acn_pkg::VAL_W-1:0] out_value_x,
  input logic signed [acn_pkg::VAL_W-1:0] out_value_y,
  input logic                             out_is_down,
  input logic                             out_went_down,
  input logic                             out_went_up
);

  a_press_is_down : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_went_down |-> out_is_down)
    else $error("press edge without the action down");

  a_release_is_up : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_went_up |-> !out_is_down)
    else $error("release edge with the action still down");

  a_value_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_value_x <= acn_pkg::ONE_V && out_value_x >= acn_pkg::NEG_ONE_V &&
                  out_value_y <= acn_pkg::ONE_V && out_value_y >= acn_pkg::NEG_ONE_V)
    else $error("result value outside -1.0 to 1.0");

  a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value_x) && $stable(out_value_y) &&
                               $stable(out_is_down) && $stable(out_went_down) &&
                               $stable(out_went_up))
    else $error("stalled result changed");

endmodule

bind input_action_conditioner_core acn_checker u_acn_checker (.*);

@@ tb/tb_input_action_conditioner_core.sv @@
module tb_input_action_conditioner_core;
  timeunit 1ns;
  timeprecision 1ps;

  // 1.0 in the block's fixed-point format
  localparam longint UNIT         = longint'(1) << acn_pkg::FRACTION_BITS;
  // cycles to watch the result port after the last transfer
  localparam int     DRAIN_CYCLES = 40;
  localparam int     REPORT_LIMIT = 10;

  // digital inputs packed as {key, neg_x, pos_x, neg_y, pos_y}
  localparam logic [4:0] D_NONE  = 5'b00000;
  localparam logic [4:0] D_KEY   = 5'b10000;
  localparam logic [4:0] D_NEG_X = 5'b01000;
  localparam logic [4:0] D_POS_X = 5'b00100;
  localparam logic [4:0] D_NEG_Y = 5'b00010;
  localparam logic [4:0] D_POS_Y = 5'b00001;

  localparam logic [acn_pkg::SRC_W-1:0] SRC_ALL        = acn_pkg::SOURCE_ENABLE_RST;
  localparam logic [acn_pkg::SRC_W-1:0] SRC_NONE       = '0;
  localparam logic [acn_pkg::SRC_W-1:0] SRC_STICK_ONLY =
    acn_pkg::SRC_W'(1 << acn_pkg::SRC_STICK);
  localparam logic [acn_pkg::SRC_W-1:0] SRC_TILT_STICK =
    acn_pkg::SRC_W'((1 << acn_pkg::SRC_TILT) | (1 << acn_pkg::SRC_STICK));
  localparam logic [acn_pkg::INV_W-1:0] INV_NONE       = '0;
  localparam logic [acn_pkg::INV_W-1:0] INV_XONLY      = acn_pkg::INV_W'(1 << acn_pkg::INV_X);
  localparam logic [acn_pkg::INV_W-1:0] INV_YONLY      = acn_pkg::INV_W'(1 << acn_pkg::INV_Y);
  localparam logic [acn_pkg::INV_W-1:0] INV_BOTH       =
    acn_pkg::INV_W'((1 << acn_pkg::INV_X) | (1 << acn_pkg::INV_Y));

  typedef struct packed {
    logic                               key;
    logic                               neg_x;
    logic                               pos_x;
    logic                               neg_y;
    logic                               pos_y;
    logic signed [acn_pkg::TILT_W-1:0]  tilt_x;
    logic signed [acn_pkg::TILT_W-1:0]  tilt_y;
    logic                               button;
    logic signed [acn_pkg::STICK_W-1:0] stick_x;
    logic signed [acn_pkg::STICK_W-1:0] stick_y;
  } frame_t;

  typedef struct packed {
    acn_pkg::val_t value_x;
    acn_pkg::val_t value_y;
    logic          is_down;
    logic          went_down;
    logic          went_up;
  } action_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                               cfg_we    = 1'b0;
  logic [acn_pkg::CFG_IDX_W-1:0]      cfg_index = acn_pkg::CFG_DEAD_ZONE;
  logic [acn_pkg::CFG_DATA_W-1:0]     cfg_data  = '0;

  logic                               in_valid       = 1'b0;
  logic                               in_stall;
  logic                               in_key_held    = 1'b0;
  logic                               in_neg_x_held  = 1'b0;
  logic                               in_pos_x_held  = 1'b0;
  logic                               in_neg_y_held  = 1'b0;
  logic                               in_pos_y_held  = 1'b0;
  logic signed [acn_pkg::TILT_W-1:0]  in_tilt_x      = '0;
  logic signed [acn_pkg::TILT_W-1:0]  in_tilt_y      = '0;
  logic                               in_button_held = 1'b0;
  logic signed [acn_pkg::STICK_W-1:0] in_stick_x     = '0;
  logic signed [acn_pkg::STICK_W-1:0] in_stick_y     = '0;

  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic signed [acn_pkg::VAL_W-1:0]   out_value_x;
  logic signed [acn_pkg::VAL_W-1:0]   out_value_y;
  logic                               out_is_down;
  logic                               out_went_down;
  logic                               out_went_up;

  // Own copy of the registers and of the previous-frame down flag, at reset values
  logic [acn_pkg::DZ_W-1:0]  dz_mirror  = '0;
  logic [acn_pkg::INV_W-1:0] inv_mirror = '0;
  logic [acn_pkg::SRC_W-1:0] src_mirror = acn_pkg::SOURCE_ENABLE_RST;
  logic                      prev_down  = 1'b0;

  frame_t  frames_to_send[$];   // frames waiting for the driver
  action_t actions_due[$];      // predicted results, oldest first
  frame_t  held;                // frame currently on the input ports

  int   gap_left       = 0;
  int   stall_left     = 0;
  int   mismatch_count = 0;
  logic quiet          = 1'b0;  // set for the closing phase: no idling on either side

  input_action_conditioner_core i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_key_held   (in_key_held),
    .in_neg_x_held (in_neg_x_held),
    .in_pos_x_held (in_pos_x_held),
    .in_neg_y_held (in_neg_y_held),
    .in_pos_y_held (in_pos_y_held),
    .in_tilt_x     (in_tilt_x),
    .in_tilt_y     (in_tilt_y),
    .in_button_held(in_button_held),
    .in_stick_x    (in_stick_x),
    .in_stick_y    (in_stick_y),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value_x   (out_value_x),
    .out_value_y   (out_value_y),
    .out_is_down   (out_is_down),
    .out_went_down (out_went_down),
    .out_went_up   (out_went_up)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Action predictor
  // ---------------------------------------------------------------------------

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // The candidate replaces the running value on greater or equal magnitude,
  // so on a tie the later source wins.
  function automatic longint stronger_of(longint cur, longint cand);
    return (magnitude(cand) >= magnitude(cur)) ? cand : cur;
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v > UNIT) return UNIT;
    if (v < -UNIT) return -UNIT;
    return v;
  endfunction

  // Deadzone and rescale of one stick axis; a zero width only clamps.
  function automatic longint rescale_stick(longint raw);
    longint dz;
    longint m;
    longint q;
    dz = longint'(dz_mirror);
    m  = magnitude(raw);
    if (dz == 0) return clamp_unit(raw);
    if (dz >= UNIT || m <= dz) return 0;
    q = ((m - dz) * UNIT) / (UNIT - dz);
    if (q > UNIT) q = UNIT;
    return (raw < 0) ? -q : q;
  endfunction

  // Combine the enabled sources in fixed order, then advance the edge state.
  function automatic action_t predict_action(frame_t f);
    longint  x;
    longint  y;
    longint  sx;
    longint  sy;
    logic    now;
    action_t r;
    x = 0;
    y = 0;
    if (src_mirror[acn_pkg::SRC_KEY])    x = stronger_of(x, f.key ? UNIT : 0);
    if (src_mirror[acn_pkg::SRC_BUTTON]) x = stronger_of(x, f.button ? UNIT : 0);
    if (src_mirror[acn_pkg::SRC_KEY_AXES]) begin
      x = stronger_of(x, (f.pos_x ? UNIT : 0) - (f.neg_x ? UNIT : 0));
      y = stronger_of(y, (f.pos_y ? UNIT : 0) - (f.neg_y ? UNIT : 0));
    end
    if (src_mirror[acn_pkg::SRC_TILT]) begin
      x = stronger_of(x, clamp_unit(longint'(f.tilt_x)));
      y = stronger_of(y, clamp_unit(longint'(f.tilt_y)));
    end
    if (src_mirror[acn_pkg::SRC_STICK]) begin
      sx = rescale_stick(longint'(f.stick_x));
      sy = rescale_stick(longint'(f.stick_y));
      if (inv_mirror[acn_pkg::INV_X]) sx = -sx;
      if (inv_mirror[acn_pkg::INV_Y]) sy = -sy;
      x = stronger_of(x, sx);
      y = stronger_of(y, sy);
    end
    now         = (x * x + y * y) > ((UNIT * UNIT) / 4);
    r.value_x   = acn_pkg::VAL_W'(x);
    r.value_y   = acn_pkg::VAL_W'(y);
    r.is_down   = now;
    r.went_down = now && !prev_down;
    r.went_up   = !now && prev_down;
    prev_down   = now;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Frame construction
  // ---------------------------------------------------------------------------

  function automatic frame_t make_frame(logic [4:0] digital, logic button,
                                        int tx, int ty, int sx, int sy);
    frame_t f;
    {f.key, f.neg_x, f.pos_x, f.neg_y, f.pos_y} = digital;
    f.button  = button;
    f.tilt_x  = acn_pkg::TILT_W'(tx);
    f.tilt_y  = acn_pkg::TILT_W'(ty);
    f.stick_x = acn_pkg::STICK_W'(sx);
    f.stick_y = acn_pkg::STICK_W'(sy);
    return f;
  endfunction

  // Mostly in range; now and then anywhere in the 17-bit field or at an edge.
  function automatic int tilt_sample();
    int v;
    case ($urandom_range(0, 5))
      0: v = int'($urandom_range(0, 131071)) - 65536;
      1: begin
        case ($urandom_range(0, 4))
          0:       v = 32768;
          1:       v = -32768;
          2:       v = 65535;
          3:       v = -65536;
          default: v = 32767;
        endcase
      end
      2:       v = 0;
      default: v = int'($urandom_range(0, 65536)) - 32768;
    endcase
    return v;
  endfunction

  // Bias towards the deadzone edge, the rails and small deflections.
  function automatic int stick_sample();
    int v;
    case ($urandom_range(0, 5))
      0: v = int'($urandom_range(0, 600)) - 300;
      1: begin
        v = int'(dz_mirror) + int'($urandom_range(0, 6)) - 3;
        if (v > 32767) v = 32767;
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      2:       v = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    return v;
  endfunction

  function automatic frame_t random_frame();
    logic [4:0] digital;
    digital = 5'($urandom);
    // keep digital sources off half the time so the analogue ones get a say
    if ($urandom_range(0, 1) == 0) digital = D_NONE;
    return make_frame(digital, $urandom_range(0, 3) == 0,
                      tilt_sample(), tilt_sample(), stick_sample(), stick_sample());
  endfunction

  // ---------------------------------------------------------------------------
  // Sequencing helpers
  // ---------------------------------------------------------------------------

  // Append a frame at the tail of the driver's list.
  function automatic void queue_frame(frame_t f);
    frames_to_send.insert(frames_to_send.size(), f);
  endfunction

  // Append a prediction at the tail of the pending results.
  function automatic void note_action(action_t a);
    actions_due.insert(actions_due.size(), a);
  endfunction

  // Wait until every frame has been transferred and every result has arrived.
  task automatic wait_idle();
    do @(negedge clk);
    while (frames_to_send.size() != 0 || in_valid || actions_due.size() != 0);
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) queue_frame(random_frame());
    wait_idle();
  endtask

  // Write all three registers back to back; spare data bits carry noise.
  task automatic set_config(input logic [acn_pkg::DZ_W-1:0] dz,
                            input logic [acn_pkg::INV_W-1:0] inv,
                            input logic [acn_pkg::SRC_W-1:0] src);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= acn_pkg::CFG_DEAD_ZONE;
    cfg_data  <= acn_pkg::CFG_DATA_W'(dz);
    @(posedge clk);
    cfg_index <= acn_pkg::CFG_INVERT_MASK;
    cfg_data  <= {(acn_pkg::CFG_DATA_W - acn_pkg::INV_W)'($urandom), inv};
    @(posedge clk);
    cfg_index <= acn_pkg::CFG_SOURCE_ENABLE;
    cfg_data  <= {(acn_pkg::CFG_DATA_W - acn_pkg::SRC_W)'($urandom), src};
    @(posedge clk);
    cfg_we     <= 1'b0;
    dz_mirror  = dz;
    inv_mirror = inv;
    src_mirror = src;
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: predict on every transfer, then load the next frame or idle
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : frame_driver
    logic load;
    load = 1'b0;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        note_action(predict_action(held));
      end
      // a stalled frame must hold, so only touch the ports once the slot is free
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (frames_to_send.size() != 0) begin
          if (!quiet && $urandom_range(0, 7) == 0) begin
            // start an idle burst here, this cycle included
            gap_left = $urandom_range(0, 11);
          end else begin
            held = frames_to_send.pop_front();
            load = 1'b1;
          end
        end
        in_valid <= load;
        if (load) begin
          in_key_held    <= held.key;
          in_neg_x_held  <= held.neg_x;
          in_pos_x_held  <= held.pos_x;
          in_neg_y_held  <= held.neg_y;
          in_pos_y_held  <= held.pos_y;
          in_tilt_x      <= held.tilt_x;
          in_tilt_y      <= held.tilt_y;
          in_button_held <= held.button;
          in_stick_x     <= held.stick_x;
          in_stick_y     <= held.stick_y;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: check each transfer against the oldest prediction,
  // and stall in random bursts
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : result_monitor
    action_t want;
    action_t seen;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        seen.value_x   = out_value_x;
        seen.value_y   = out_value_y;
        seen.is_down   = out_is_down;
        seen.went_down = out_went_down;
        seen.went_up   = out_went_up;
        if (actions_due.size() == 0) begin
          if (mismatch_count < REPORT_LIMIT)
            $display("%0t: result with none expected: x %0d y %0d down %0b/%0b/%0b",
                     $time, seen.value_x, seen.value_y,
                     seen.is_down, seen.went_down, seen.went_up);
          mismatch_count++;
        end else begin
          want = actions_due.pop_front();
          if (seen !== want) begin
            if (mismatch_count < REPORT_LIMIT)
              $display({"%0t: mismatch x %0d/%0d y %0d/%0d down %0b/%0b ",
                        "went_down %0b/%0b went_up %0b/%0b (expected/actual)"},
                       $time, want.value_x, seen.value_x, want.value_y, seen.value_y,
                       want.is_down, seen.is_down, want.went_down, seen.went_down,
                       want.went_up, seen.went_up);
            mismatch_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        // start a stall burst here, this cycle included
        stall_left = $urandom_range(0, 11);
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin : sequencer
    logic [acn_pkg::DZ_W-1:0] dz;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: no deadzone, no inversion, every source enabled.
    queue_frame(make_frame(D_NONE, 1'b0, 0, 0, 0, 0));
    queue_frame(make_frame(D_KEY, 1'b0, 0, 0, 0, 0));
    queue_frame(make_frame(D_KEY, 1'b1, 0, 0, 0, 0));
    queue_frame(make_frame(D_NONE, 1'b1, 0, 0, 0, 0));
    // both keys of an axis cancel
    queue_frame(make_frame(D_NEG_X | D_POS_X | D_NEG_Y | D_POS_Y, 1'b0, 0, 0, 0, 0));
    queue_frame(make_frame(D_NEG_X, 1'b0, 0, 0, 0, 0));
    queue_frame(make_frame(D_POS_Y, 1'b0, 0, 0, 0, 0));
    queue_frame(make_frame(D_NEG_Y, 1'b0, 0, 0, 0, 0));
    // tilt beyond the unit range saturates
    queue_frame(make_frame(D_NONE, 1'b0, 65535, -65536, 0, 0));
    queue_frame(make_frame(D_NONE, 1'b0, -65536, 32768, 0, 0));
    // equal magnitude: the later tilt replaces the key
    queue_frame(make_frame(D_KEY, 1'b0, -32768, 0, 0, 0));
    // exactly one half is not down, one step more is
    queue_frame(make_frame(D_NONE, 1'b0, 16384, 0, 0, 0));
    queue_frame(make_frame(D_NONE, 1'b0, 16385, 0, 0, 0));
    queue_frame(make_frame(D_NONE, 1'b0, 0, -16384, 0, 0));
    // raw stick at the rails, clamp only
    queue_frame(make_frame(D_NONE, 1'b0, 0, 0, -32768, 32767));
    // ties between tilt and stick go to the stick
    queue_frame(make_frame(D_NONE, 1'b0, 32767, 1, 32767, -1));
    queue_frame(make_frame(D_NONE, 1'b0, -5, 7, 5, -7));
    send_random(110);

    // Deadzone edge, rescale and inversion on both axes.
    set_config(acn_pkg::DZ_W'(3000), INV_BOTH, SRC_ALL);
    queue_frame(make_frame(D_NONE, 1'b0, 0, 0, 3000, -3000));
    queue_frame(make_frame(D_NONE, 1'b0, 0, 0, 3001, -3001));
    queue_frame(make_frame(D_NONE, 1'b0, 0, 0, -32768, 32767));
    queue_frame(make_frame(D_KEY, 1'b0, 0, 0, 32767, 0));
    send_random(110);

    // Deadzone of exactly one: the stick is all dead.
    set_config(acn_pkg::DZ_W'(32768), INV_NONE, SRC_STICK_ONLY);
    send_random(100);

    set_config(acn_pkg::DZ_W'(0), INV_YONLY, SRC_STICK_ONLY);
    send_random(110);

    // Widest deadzone the register holds.
    set_config(acn_pkg::DZ_W'(65535), INV_XONLY, SRC_ALL);
    send_random(110);

    // Nothing enabled: always zero.
    set_config(acn_pkg::DZ_W'(1), INV_NONE, SRC_NONE);
    queue_frame(make_frame(D_KEY | D_POS_X | D_POS_Y, 1'b1, 32768, 32768,
                           32767, 32767));
    send_random(60);

    set_config(acn_pkg::DZ_W'(32767), INV_BOTH, SRC_TILT_STICK);
    send_random(100);

    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 3))
        0:       dz = acn_pkg::DZ_W'(0);
        1:       dz = acn_pkg::DZ_W'($urandom_range(1, 32767));
        2:       dz = acn_pkg::DZ_W'(32768);
        default: dz = acn_pkg::DZ_W'($urandom);
      endcase
      set_config(dz, acn_pkg::INV_W'($urandom), acn_pkg::SRC_W'($urandom));
      send_random(80);
    end

    // Closing phase at full rate on both sides.
    quiet = 1'b1;
    set_config(acn_pkg::DZ_W'(12000), INV_XONLY, SRC_ALL);
    send_random(120);

    // Let any stray result show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && actions_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest correct run.
  initial begin : watchdog
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
